@@ hw/rtl/src_pkg.sv @@
// Shared types and constants for the segment/rectangle crossing test.
`default_nettype none

package src_pkg;

    // Default coordinate width (signed Q8.23 at 32 bits)
    localparam int COORD_WIDTH_DEFAULT = 32;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RECT_X_LOW  = 2'd0,
        REG_RECT_Y_LOW  = 2'd1,
        REG_RECT_X_HIGH = 2'd2,
        REG_RECT_Y_HIGH = 2'd3
    } cfg_reg_t;

    // Sign of an orientation value
    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } sign_t;

    // True when two signs are strictly opposite
    function automatic logic opposite(input sign_t a, input sign_t b);
        logic r;
        r = ((a == SGN_POS) && (b == SGN_NEG)) || ((a == SGN_NEG) && (b == SGN_POS));
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/src_pipe.sv @@
// Four-stage datapath: differences, products, orientation signs, side combine.
`default_nettype none

module src_pipe #(
    parameter int COORD_WIDTH = src_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] rect_x_low,
    input  wire logic signed [COORD_WIDTH-1:0] rect_y_low,
    input  wire logic signed [COORD_WIDTH-1:0] rect_x_high,
    input  wire logic signed [COORD_WIDTH-1:0] rect_y_high,
    output logic                               out_valid,
    output logic                               hit,
    output logic                               start_inside
);
    import src_pkg::*;

    localparam int DW = COORD_WIDTH + 1;   // exact difference
    localparam int PW = 2 * DW;            // exact product
    localparam int SW = PW + 1;            // exact product difference

    // Stage 1: coordinate differences, inside test, straddle flags
    logic signed [DW-1:0] dx_next, dy_next, dyl_next, dyh_next, dxl_next, dxh_next;
    logic signed [DW-1:0] dx_reg, dy_reg, dyl_reg, dyh_reg, dxl_reg, dxh_reg;
    logic                 inside_next;
    logic [3:0]           strad_next;
    logic                 v1_reg, inside1_reg;
    logic [3:0]           strad1_reg;

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [DW-1:0] r;
        r = $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
        return r;
    endfunction

    // Points p and q strictly on opposite sides of level c
    function automatic logic straddle(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q,
        input logic signed [COORD_WIDTH-1:0] c
    );
        logic r;
        r = ((p < c) && (q > c)) || ((p > c) && (q < c));
        return r;
    endfunction

    always_comb
    begin
        dx_next  = sdiff(seg_end_x, seg_start_x);
        dy_next  = sdiff(seg_end_y, seg_start_y);
        dyl_next = sdiff(rect_y_low, seg_start_y);
        dyh_next = sdiff(rect_y_high, seg_start_y);
        dxl_next = sdiff(rect_x_low, seg_start_x);
        dxh_next = sdiff(rect_x_high, seg_start_x);
        inside_next = (seg_start_x < rect_x_high) && (rect_x_low < seg_start_x) &&
                      (seg_start_y < rect_y_high) && (rect_y_low < seg_start_y);
        // side 0: x = x_low, side 1: y = y_low, side 2: x = x_high, side 3: y = y_high
        strad_next[0] = (rect_y_high != rect_y_low) &&
                        straddle(seg_start_x, seg_end_x, rect_x_low);
        strad_next[1] = (rect_x_high != rect_x_low) &&
                        straddle(seg_start_y, seg_end_y, rect_y_low);
        strad_next[2] = (rect_y_high != rect_y_low) &&
                        straddle(seg_start_x, seg_end_x, rect_x_high);
        strad_next[3] = (rect_x_high != rect_x_low) &&
                        straddle(seg_start_y, seg_end_y, rect_y_high);
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dyl_reg     <= dyl_next;
        dyh_reg     <= dyh_next;
        dxl_reg     <= dxl_next;
        dxh_reg     <= dxh_next;
        inside1_reg <= inside_next;
        strad1_reg  <= strad_next;
    end

    // Stage 2: the four shared products
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic                 v2_reg, inside2_reg;
    logic [3:0]           strad2_reg;

    always_ff @(posedge clk)
    begin
        pa_reg      <= dx_reg * dyl_reg;
        pb_reg      <= dx_reg * dyh_reg;
        pc_reg      <= dy_reg * dxl_reg;
        pd_reg      <= dy_reg * dxh_reg;
        inside2_reg <= inside1_reg;
        strad2_reg  <= strad1_reg;
    end

    // Stage 3: orientation signs of the rectangle corners against the segment
    function automatic sign_t sign_of_sub(
        input logic signed [PW-1:0] p,
        input logic signed [PW-1:0] q
    );
        logic signed [SW-1:0] t;
        sign_t                s;
        t = $signed({p[PW-1], p}) - $signed({q[PW-1], q});
        if (t == '0)
            s = SGN_ZERO;
        else if (t[SW-1])
            s = SGN_NEG;
        else
            s = SGN_POS;
        return s;
    endfunction

    sign_t      s_ac_reg, s_bc_reg, s_ad_reg, s_bd_reg;
    logic       v3_reg, inside3_reg;
    logic [3:0] strad3_reg;

    always_ff @(posedge clk)
    begin
        s_ac_reg    <= sign_of_sub(pa_reg, pc_reg);   // corner (x_low,  y_low)
        s_bc_reg    <= sign_of_sub(pb_reg, pc_reg);   // corner (x_low,  y_high)
        s_ad_reg    <= sign_of_sub(pa_reg, pd_reg);   // corner (x_high, y_low)
        s_bd_reg    <= sign_of_sub(pb_reg, pd_reg);   // corner (x_high, y_high)
        inside3_reg <= inside2_reg;
        strad3_reg  <= strad2_reg;
    end

    // Stage 4: proper crossing per side, then the result
    logic [3:0] side_hit;
    logic       hit_reg, inside4_reg, v4_reg;

    always_comb
    begin
        side_hit[0] = strad3_reg[0] && opposite(s_ac_reg, s_bc_reg);
        side_hit[1] = strad3_reg[1] && opposite(s_ac_reg, s_ad_reg);
        side_hit[2] = strad3_reg[2] && opposite(s_ad_reg, s_bd_reg);
        side_hit[3] = strad3_reg[3] && opposite(s_bc_reg, s_bd_reg);
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= inside3_reg | (|side_hit);
        inside4_reg <= inside3_reg;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign hit          = hit_reg;
    assign start_inside = inside4_reg;

endmodule

`default_nettype wire

@@ hw/rtl/segment_rect_cross.sv @@
// Top level: rectangle registers, command handshake and the crossing pipeline.
//
//  channel   signals                                      transaction when
//  -------   -------------------------------------------  -----------------------
//  command   start, busy, seg_start_x/y, seg_end_x/y      start & !busy at clk
//  result    result_valid, hit, start_inside              result_valid at clk
//  config    cfg_wr_en, cfg_addr, cfg_wdata               cfg_wr_en at clk
//
// One segment is taken every cycle; busy is always low.
// Results appear one per command, in order, after passing through the four
// pipeline registers (differences, products, signs, combine).
// Results are shown for one cycle only; the receiver cannot hold them off.
// rst_n clears the pipeline valid bits and the rectangle registers to zero.
`default_nettype none

module segment_rect_cross #(
    parameter int COORD_WIDTH = src_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
    // result
    output logic                               result_valid,
    output logic                               hit,
    output logic                               start_inside,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire src_pkg::cfg_reg_t             cfg_addr,
    input  wire logic [COORD_WIDTH-1:0]        cfg_wdata
);
    import src_pkg::*;

    logic signed [COORD_WIDTH-1:0] rect_x_low_reg, rect_y_low_reg;
    logic signed [COORD_WIDTH-1:0] rect_x_high_reg, rect_y_high_reg;

    // Rectangle bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_low_reg  <= '0;
            rect_y_low_reg  <= '0;
            rect_x_high_reg <= '0;
            rect_y_high_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RECT_X_LOW:  rect_x_low_reg  <= $signed(cfg_wdata);
                REG_RECT_Y_LOW:  rect_y_low_reg  <= $signed(cfg_wdata);
                REG_RECT_X_HIGH: rect_x_high_reg <= $signed(cfg_wdata);
                REG_RECT_Y_HIGH: rect_y_high_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Fully pipelined: never refuses a command
    assign busy = 1'b0;

    src_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start & ~busy),
        .seg_start_x  (seg_start_x),
        .seg_start_y  (seg_start_y),
        .seg_end_x    (seg_end_x),
        .seg_end_y    (seg_end_y),
        .rect_x_low   (rect_x_low_reg),
        .rect_y_low   (rect_y_low_reg),
        .rect_x_high  (rect_x_high_reg),
        .rect_y_high  (rect_y_high_reg),
        .out_valid    (result_valid),
        .hit          (hit),
        .start_inside (start_inside)
    );

endmodule

`default_nettype wire
